### rtl/keypad_passcode_lock_defines.svh
// Assertion macros for the keypad passcode lock.
// Both expect clk and rst_n to be visible where they are used.
`ifndef KEYPAD_PASSCODE_LOCK_DEFINES_SVH
`define KEYPAD_PASSCODE_LOCK_DEFINES_SVH

`ifndef SYNTHESIS

// Holds on every clock edge outside reset.
`define KPL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("keypad_passcode_lock: check failed");

// When the first expression holds, the second holds in the next cycle.
`define KPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad_passcode_lock: check failed one cycle after trigger");

`else

`define KPL_ASSERT(label, prop)
`define KPL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/kpl_pkg.sv
`default_nettype none

package kpl_pkg;

    localparam int CODE_DIGITS = 4;
    // position counter holds 0..CODE_DIGITS-1; its increment reaches CODE_DIGITS
    localparam int POS_W = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int SHOWN_DIGITS = (CODE_DIGITS < 4) ? CODE_DIGITS : 4;

    localparam int TIMER_W = 16;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd5000;

    typedef logic [3:0] digit_t;
    typedef digit_t [CODE_DIGITS-1:0] code_t;

    localparam digit_t KEY_LOCK = 4'd10;
    localparam digit_t KEY_EDIT = 4'd11;
    localparam digit_t KEY_ZERO = 4'd0;

    localparam logic [1:0] COL_LOCK = 2'd0;
    localparam logic [1:0] COL_ZERO = 2'd1;
    localparam logic [1:0] COL_EDIT = 2'd2;
    localparam logic [1:0] COL_NONE = 2'd3;
    localparam logic [1:0] ROW_BOTTOM = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;
    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_ENTER = 1'b1;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_PENDING  = 3'd1,
        ST_SUCCESS  = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_REJECTED = 3'd4,
        ST_LOCK     = 3'd5,
        ST_EDIT     = 3'd6
    } status_t;

    typedef struct packed {
        logic       command;
        logic       mode;
        logic [1:0] key_row;
        logic [1:0] key_col;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic        store_request;
        logic [15:0] passcode_word;
    } out_word_t;

    // first digit in the low nibble; only the first four digits are shown
    function automatic logic [15:0] pack_code(input code_t code);
        logic [15:0] word;
        word = '0;
        for (int i = 0; i < SHOWN_DIGITS; i++) begin
            word[4*i +: 4] = code[i];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

### rtl/keypad_passcode_lock.sv
// Channel   Direction  Handshake                Word
// in        input      in_valid / in_ready      kpl_pkg::in_word_t
// out       output     out_valid / out_ready    kpl_pkg::out_word_t
// cfg       input      cfg_wr_en (no wait)      cfg_wr_data[15:0] (timeout_ticks)
//
// One word per cycle while in_ready is high: each word is decoded and applied to
// the lock state in the cycle it is accepted; its result is registered in the
// output register, or in the skid register behind it if out is stalled. The skid
// register lets one more word in while the output is stalled; in_ready drops only when both are full.
// Reset clears the entry buffers, stored code and timer; timeout_ticks = 5000.

`default_nettype none

module keypad_passcode_lock (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire kpl_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output kpl_pkg::out_word_t      out_word,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data
);

    kpl_pkg::out_word_t out_word_reg;
    kpl_pkg::out_word_t skid_word_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               step;
    kpl_pkg::out_word_t result;

    assign in_ready  = !skid_valid_reg;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    kpl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            // output stalled: park the new word
            if (step)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b1;
        end
        else
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (step)
            begin
                skid_word_reg <= result;
            end
        end
        else if (skid_valid_reg)
        begin
            out_word_reg <= skid_word_reg;
        end
        else if (step)
        begin
            out_word_reg <= result;
        end
    end

`include "keypad_passcode_lock_defines.svh"

    `KPL_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `KPL_ASSERT_NEXT(a_stall_parks_word, step && out_valid_reg && !out_ready, skid_valid_reg)
    `KPL_ASSERT(a_store_is_success,
        !(out_valid_reg && out_word_reg.store_request) || (out_word_reg.status == kpl_pkg::ST_SUCCESS))
    `KPL_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

### rtl/kpl_core.sv
`default_nettype none

module kpl_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire kpl_pkg::in_word_t  item,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    output kpl_pkg::out_word_t      result
);

    logic [kpl_pkg::POS_W-1:0]   set_pos_reg, set_pos_next;
    logic [kpl_pkg::POS_W-1:0]   enter_pos_reg, enter_pos_next;
    kpl_pkg::code_t              set_buf_reg, set_buf_next;
    kpl_pkg::code_t              enter_buf_reg, enter_buf_next;
    kpl_pkg::code_t              stored_reg, stored_next;
    logic                        timer_run_reg, timer_run_next;
    logic [kpl_pkg::TIMER_W-1:0] timer_cnt_reg, timer_cnt_next;
    logic [kpl_pkg::TIMER_W-1:0] timeout_reg;

    kpl_pkg::digit_t             key;
    logic                        is_lock;
    logic                        is_edit;
    kpl_pkg::code_t              buf_cur;
    kpl_pkg::code_t              buf_wr;
    logic [kpl_pkg::POS_W-1:0]   pos_cur;
    logic [kpl_pkg::POS_W-1:0]   pos_inc;
    logic                        full;
    logic [kpl_pkg::TIMER_W-1:0] cnt_inc;
    logic                        expired;
    logic                        clr;
    logic                        stop;
    kpl_pkg::status_t            status;
    logic                        store;

    // key decode
    always_comb
    begin
        key     = {2'b00, item.key_col} * 4'd3 + {2'b00, item.key_row} + 4'd1;
        is_lock = 1'b0;
        is_edit = 1'b0;
        if (item.key_row == kpl_pkg::ROW_BOTTOM)
        begin
            case (item.key_col)
                kpl_pkg::COL_LOCK:
                begin
                    key     = kpl_pkg::KEY_LOCK;
                    is_lock = 1'b1;
                end
                kpl_pkg::COL_EDIT:
                begin
                    key     = kpl_pkg::KEY_EDIT;
                    is_edit = 1'b1;
                end
                default: key = kpl_pkg::KEY_ZERO;
            endcase
        end
    end

    always_comb
    begin
        buf_cur = (item.mode == kpl_pkg::MODE_SET) ? set_buf_reg : enter_buf_reg;
        pos_cur = (item.mode == kpl_pkg::MODE_SET) ? set_pos_reg : enter_pos_reg;
        buf_wr  = buf_cur;
        buf_wr[pos_cur[kpl_pkg::IDX_W-1:0]] = key;
        pos_inc = pos_cur + 1'b1;
        full    = (pos_inc == kpl_pkg::POS_W'(kpl_pkg::CODE_DIGITS));
        // saturating tick count
        cnt_inc = (timer_run_reg && (timer_cnt_reg != '1)) ? timer_cnt_reg + 1'b1
                                                            : timer_cnt_reg;
        expired = (cnt_inc > timeout_reg);
    end

    always_comb
    begin
        set_pos_next   = set_pos_reg;
        enter_pos_next = enter_pos_reg;
        set_buf_next   = set_buf_reg;
        enter_buf_next = enter_buf_reg;
        stored_next    = stored_reg;
        timer_run_next = timer_run_reg;
        timer_cnt_next = timer_cnt_reg;
        status         = kpl_pkg::ST_NONE;
        store          = 1'b0;
        clr            = 1'b0;
        stop           = 1'b0;

        if (step)
        begin
            if (item.command == kpl_pkg::CMD_TICK)
            begin
                timer_cnt_next = cnt_inc;
                if (expired)
                begin
                    clr    = 1'b1;
                    stop   = 1'b1;
                    status = kpl_pkg::ST_TIMEOUT;
                end
            end
            else if (item.key_col != kpl_pkg::COL_NONE)
            begin
                if (is_lock || is_edit)
                begin
                    clr    = 1'b1;
                    stop   = 1'b1;
                    status = is_lock ? kpl_pkg::ST_LOCK : kpl_pkg::ST_EDIT;
                end
                else if (full)
                begin
                    clr  = 1'b1;
                    stop = 1'b1;
                    if (item.mode == kpl_pkg::MODE_SET)
                    begin
                        stored_next = buf_wr;
                        store       = 1'b1;
                        status      = kpl_pkg::ST_SUCCESS;
                    end
                    else
                    begin
                        status = (buf_wr == stored_reg) ? kpl_pkg::ST_SUCCESS
                                                        : kpl_pkg::ST_REJECTED;
                    end
                end
                else
                begin
                    if (item.mode == kpl_pkg::MODE_SET)
                    begin
                        set_buf_next = buf_wr;
                        set_pos_next = pos_inc;
                    end
                    else
                    begin
                        enter_buf_next = buf_wr;
                        enter_pos_next = pos_inc;
                    end
                    timer_run_next = 1'b1;
                    timer_cnt_next = '0;
                    status         = kpl_pkg::ST_PENDING;
                end
            end
        end

        if (clr)
        begin
            if (item.mode == kpl_pkg::MODE_SET)
            begin
                set_pos_next = '0;
                set_buf_next = '0;
            end
            else
            begin
                enter_pos_next = '0;
                enter_buf_next = '0;
            end
        end
        if (stop)
        begin
            timer_run_next = 1'b0;
            timer_cnt_next = '0;
        end
    end

    always_comb
    begin
        result.status        = status;
        result.store_request = store;
        result.passcode_word = kpl_pkg::pack_code(stored_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_pos_reg   <= '0;
            enter_pos_reg <= '0;
            set_buf_reg   <= '0;
            enter_buf_reg <= '0;
            stored_reg    <= '0;
            timer_run_reg <= 1'b0;
            timer_cnt_reg <= '0;
            timeout_reg   <= kpl_pkg::TIMEOUT_RESET;
        end
        else
        begin
            set_pos_reg   <= set_pos_next;
            enter_pos_reg <= enter_pos_next;
            set_buf_reg   <= set_buf_next;
            enter_buf_reg <= enter_buf_next;
            stored_reg    <= stored_next;
            timer_run_reg <= timer_run_next;
            timer_cnt_reg <= timer_cnt_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire
